### rtl/ldhn_pkg.sv
// ----------------------------------------------------------------------------
// ldhn_pkg: shared types and constants of the domain name normalizer
// Character codes, counter limits, register indexes and the per-name
// checker state carried between the checker and the top level.
// ----------------------------------------------------------------------------
package ldhn_pkg;

    localparam int unsigned LABEL_CNT_W = 7;
    localparam int unsigned NAME_CNT_W  = 9;

    localparam logic [LABEL_CNT_W-1:0] LABEL_SAT = '1;
    localparam logic [NAME_CNT_W-1:0]  NAME_SAT  = '1;

    localparam logic [7:0] ASCII_TOP = 8'h7f;
    localparam logic [7:0] CH_HYPHEN = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    localparam logic [7:0] MAX_NAME_RST  = 8'd253;
    localparam logic [5:0] MAX_LABEL_RST = 6'd63;

    typedef enum logic {
        REG_MAX_NAME  = 1'b0,
        REG_MAX_LABEL = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_INVALID  = 2'd1,
        VERDICT_NONASCII = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [LABEL_CNT_W-1:0] label_count;
        logic [NAME_CNT_W-1:0]  name_count;
        logic                   prev_was_hyphen;
        logic                   invalid_seen;
        logic                   nonascii_seen;
    } t_chk_state;

    localparam t_chk_state CHK_STATE_CLR = '{default: '0};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kept;
        logic       final_res;
        t_verdict   verdict;
    } t_chk_result;

endpackage

### rtl/ldhn_check.sv
// ----------------------------------------------------------------------------
// ldhn_check: per-byte rule check and lower-case mapping
// Combinational update of the per-name checker state for one byte, and the
// result item that the byte produces.
// ----------------------------------------------------------------------------
module ldhn_check (
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_max_name,
    input  logic [5:0]           i_max_label,
    input  ldhn_pkg::t_chk_state i_state,
    output ldhn_pkg::t_chk_state o_state,
    output ldhn_pkg::t_chk_result o_result
);

    logic [7:0]                       lower;
    logic                             is_dot;
    logic                             is_hyphen;
    logic                             is_ldh;
    logic                             drop_dot;
    logic [ldhn_pkg::LABEL_CNT_W-1:0] label_inc;
    logic [ldhn_pkg::NAME_CNT_W-1:0]  name_inc;
    logic                             label_empty;
    ldhn_pkg::t_chk_state             upd;

    always_comb begin
        if (i_byte >= ldhn_pkg::CH_UP_A && i_byte <= ldhn_pkg::CH_UP_Z) begin
            lower = i_byte + ldhn_pkg::CASE_DIFF;
        end else begin
            lower = i_byte;
        end
    end

    assign is_dot    = (i_byte == ldhn_pkg::CH_DOT);
    assign is_hyphen = (lower == ldhn_pkg::CH_HYPHEN);
    assign is_ldh    = (lower >= ldhn_pkg::CH_LO_A && lower <= ldhn_pkg::CH_LO_Z)
                     || (lower >= ldhn_pkg::CH_ZERO && lower <= ldhn_pkg::CH_NINE)
                     || is_hyphen;
    assign drop_dot  = is_dot && i_last;

    assign label_inc = (i_state.label_count == ldhn_pkg::LABEL_SAT)
                     ? i_state.label_count
                     : i_state.label_count + 1'b1;
    assign name_inc  = (i_state.name_count == ldhn_pkg::NAME_SAT)
                     ? i_state.name_count
                     : i_state.name_count + 1'b1;
    assign label_empty = (i_state.label_count == '0);

    always_comb begin
        upd = i_state;
        if (drop_dot) begin
            if (label_empty || i_state.prev_was_hyphen) begin
                upd.invalid_seen = 1'b1;
            end
        end else begin
            upd.name_count = name_inc;
            if (name_inc > {1'b0, i_max_name}) begin
                upd.invalid_seen = 1'b1;
            end
            if (i_byte > ldhn_pkg::ASCII_TOP) begin
                upd.nonascii_seen = 1'b1;
            end
            if (is_dot) begin
                if (label_empty || i_state.prev_was_hyphen) begin
                    upd.invalid_seen = 1'b1;
                end
                upd.label_count     = '0;
                upd.prev_was_hyphen = 1'b0;
            end else begin
                if (!is_ldh || (is_hyphen && label_empty)) begin
                    upd.invalid_seen = 1'b1;
                end
                if (label_inc > {1'b0, i_max_label}) begin
                    upd.invalid_seen = 1'b1;
                end
                // The label count is never zero after a label byte, so only a
                // closing hyphen breaks the rule on the last byte.
                if (i_last && is_hyphen) begin
                    upd.invalid_seen = 1'b1;
                end
                upd.label_count     = label_inc;
                upd.prev_was_hyphen = is_hyphen;
            end
        end
    end

    always_comb begin
        o_result.out_byte  = lower;
        o_result.kept      = !drop_dot;
        o_result.final_res = i_last;
        if (upd.nonascii_seen) begin
            o_result.verdict = ldhn_pkg::VERDICT_NONASCII;
        end else if (upd.invalid_seen) begin
            o_result.verdict = ldhn_pkg::VERDICT_INVALID;
        end else begin
            o_result.verdict = ldhn_pkg::VERDICT_VALID;
        end
        o_state = i_last ? ldhn_pkg::CHK_STATE_CLR : upd;
    end

endmodule

### rtl/domain_name_ldh_normalizer.sv
// ----------------------------------------------------------------------------
// domain_name_ldh_normalizer: streaming domain name check and lower-casing
// The block takes a domain name one byte per item, tlast on its final byte,
// and returns one item per byte, registered first in an input register and
// then in a result register: the byte with A-Z mapped to a-z, a kept flag
// that is low only for a dropped trailing dot, and a sticky verdict (valid,
// invalid, non-ASCII) that is final on the item with tlast. One byte is
// taken every cycle while the output side accepts; the rate is set by the
// single pass through an input register and a result register, with the
// per-name counters updated in that same cycle. Writes to the length
// limits are taken at any time and should be made between names.
// ----------------------------------------------------------------------------
module domain_name_ldh_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] verdict, rest zero
    output logic        m_axis_tuser,   // kept
    output logic        m_axis_tlast    // final_res
);

    logic                  r_max_name;
    logic [7:0]            r_max_name_len;
    logic [5:0]            r_max_label_len;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    ldhn_pkg::t_chk_result r_out;
    ldhn_pkg::t_chk_state  r_state;
    ldhn_pkg::t_chk_state  n_state;
    ldhn_pkg::t_chk_result n_out;
    logic                  advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_len  <= ldhn_pkg::MAX_NAME_RST;
            r_max_label_len <= ldhn_pkg::MAX_LABEL_RST;
        end else if (i_cfg_valid) begin
            case (ldhn_pkg::t_reg_idx'(i_cfg_index))
                ldhn_pkg::REG_MAX_NAME:  r_max_name_len  <= i_cfg_data;
                ldhn_pkg::REG_MAX_LABEL: r_max_label_len <= i_cfg_data[5:0];
                default:                 r_max_name_len  <= r_max_name_len;
            endcase
        end
    end

    // Last accepted configuration targeted the name limit; kept for debug.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name <= 1'b0;
        end else if (i_cfg_valid) begin
            r_max_name <= (i_cfg_index == ldhn_pkg::REG_MAX_NAME);
        end
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    ldhn_check u_check (
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_max_name  (r_max_name_len),
        .i_max_label (r_max_label_len),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= ldhn_pkg::CHK_STATE_CLR;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.verdict, r_out.out_byte};
    assign m_axis_tuser  = r_out.kept;
    assign m_axis_tlast  = r_out.final_res;

    a_cfg_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_valid) |-> (r_max_name == ($past(i_cfg_index) == ldhn_pkg::REG_MAX_NAME)))
        else $error("configuration target flag out of step");

    a_drop_is_last_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser)
            |-> (m_axis_tlast && m_axis_tdata[7:0] == ldhn_pkg::CH_DOT))
        else $error("dropped byte is not a final dot");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:8] != 2'd3))
        else $error("verdict code out of range");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_in_last) |=> (r_state == ldhn_pkg::CHK_STATE_CLR))
        else $error("checker state not cleared after final byte");

endmodule

### test/ldh_name_checker.sv
// ----------------------------------------------------------------------------
// ldh_name_checker: result predictor and comparator for the name normalizer
// Watches the register channel and both streams of the block. Every item
// taken on the input side is run through a local model of the label and name
// rules, and the predicted result is queued. Every item taken on the output
// side is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module ldh_name_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // is_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] out_byte, [9:8] verdict
    input  logic        i_m_tuser,   // kept
    input  logic        i_m_tlast,   // final_res
    output int          o_fail_count,
    output int          o_pending
);
    import ldhn_pkg::*;

    t_chk_state  name_st;
    logic [7:0]  name_limit;
    logic [5:0]  label_limit;
    t_chk_result expected_bytes [$];
    t_chk_result want;
    t_chk_result got;
    int          fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic normalize_byte(input logic [7:0] raw, input logic last,
                                  output t_chk_result res);
        logic [7:0] low;
        logic       keep;
        low  = raw;
        keep = 1'b1;
        if (raw >= CH_UP_A && raw <= CH_UP_Z) begin
            low = raw + CASE_DIFF;
        end
        if (raw == CH_DOT && last) begin
            keep = 1'b0;
            if (name_st.label_count == '0 || name_st.prev_was_hyphen) begin
                name_st.invalid_seen = 1'b1;
            end
        end else begin
            if (name_st.name_count != NAME_SAT) begin
                name_st.name_count = name_st.name_count + 1'b1;
            end
            if (name_st.name_count > name_limit) begin
                name_st.invalid_seen = 1'b1;
            end
            if (raw > ASCII_TOP) begin
                name_st.nonascii_seen = 1'b1;
            end
            if (raw == CH_DOT) begin
                if (name_st.label_count == '0 || name_st.prev_was_hyphen) begin
                    name_st.invalid_seen = 1'b1;
                end
                name_st.label_count     = '0;
                name_st.prev_was_hyphen = 1'b0;
            end else begin
                if (!((low >= CH_LO_A && low <= CH_LO_Z) ||
                      (low >= CH_ZERO && low <= CH_NINE) || low == CH_HYPHEN)) begin
                    name_st.invalid_seen = 1'b1;
                end
                if (low == CH_HYPHEN && name_st.label_count == '0) begin
                    name_st.invalid_seen = 1'b1;
                end
                if (name_st.label_count != LABEL_SAT) begin
                    name_st.label_count = name_st.label_count + 1'b1;
                end
                if (name_st.label_count > label_limit) begin
                    name_st.invalid_seen = 1'b1;
                end
                name_st.prev_was_hyphen = (low == CH_HYPHEN);
                if (last && name_st.prev_was_hyphen) begin
                    name_st.invalid_seen = 1'b1;
                end
            end
        end
        res.out_byte  = low;
        res.kept      = keep;
        res.final_res = last;
        if (name_st.nonascii_seen) begin
            res.verdict = VERDICT_NONASCII;
        end else if (name_st.invalid_seen) begin
            res.verdict = VERDICT_INVALID;
        end else begin
            res.verdict = VERDICT_VALID;
        end
        if (last) begin
            name_st = CHK_STATE_CLR;
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
        fails++;
        $display("%0t: %s mismatch, expected %02h, got %02h",
                 $time, field, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            name_st     = CHK_STATE_CLR;
            name_limit  = MAX_NAME_RST;
            label_limit = MAX_LABEL_RST;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MAX_NAME) begin
                    name_limit = i_cfg_data;
                end else begin
                    label_limit = i_cfg_data[5:0];
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.out_byte  = i_m_tdata[7:0];
                got.kept      = i_m_tuser;
                got.final_res = i_m_tlast;
                got.verdict   = t_verdict'(i_m_tdata[9:8]);
                if (expected_bytes.size() == 0) begin
                    report_field("unexpected item, out_byte", 8'h00, got.out_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        report_field("out_byte", want.out_byte, got.out_byte);
                    end
                    if (got.kept !== want.kept) begin
                        report_field("kept", 8'(want.kept), 8'(got.kept));
                    end
                    if (got.final_res !== want.final_res) begin
                        report_field("final_res", 8'(want.final_res), 8'(got.final_res));
                    end
                    if (got.verdict !== want.verdict) begin
                        report_field("verdict", 8'(want.verdict), 8'(got.verdict));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                normalize_byte(i_s_tdata, i_s_tlast, want);
                expected_bytes.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
    end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the domain name normalizer
// Sends a directed set of names covering the character classes and the
// label, hyphen, dot and length rules, then phases of random names under
// changing length limits, with random idling on both streams. The checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ldhn_pkg::*;

    localparam int NUM_ITEMS = 1450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    t_reg_idx    cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_data;
    logic        m_user;
    logic        m_last;
    logic        no_idle;
    int          fail_count;
    int          pending;
    int          items_sent;
    int          phase;
    int          phase_end;
    logic [7:0]  name_limit;
    logic [7:0]  label_limit;
    logic [7:0]  name_buf [$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    domain_name_ldh_normalizer i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    ldh_name_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 17);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_name();
        int i;
        for (i = 0; i < name_buf.size(); i++) begin
            send_byte(name_buf[i], i == name_buf.size() - 1);
        end
    endtask

    task automatic load_text(input string s);
        int i;
        name_buf.delete();
        for (i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endtask

    task automatic drain();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_limits(input logic [7:0] name_len, input logic [7:0] label_len);
        if ($urandom_range(1) == 1) begin
            write_reg(REG_MAX_NAME, name_len);
            write_reg(REG_MAX_LABEL, label_len);
        end else begin
            write_reg(REG_MAX_LABEL, label_len);
            write_reg(REG_MAX_NAME, name_len);
        end
        cfg_valid <= 1'b0;
        name_limit  = name_len;
        label_limit = label_len;
    endtask

    function automatic logic [7:0] ldh_char(input logic hyphen_ok);
        int r;
        r = $urandom_range(0, hyphen_ok ? 65 : 61);
        if (r < 26) begin
            return CH_LO_A + 8'(r);
        end else if (r < 52) begin
            return CH_UP_A + 8'(r - 26);
        end else if (r < 62) begin
            return CH_ZERO + 8'(r - 52);
        end
        return CH_HYPHEN;
    endfunction

    // Mostly well-formed names with random content, some labels near or past
    // the label limit, some broken by one bad byte, and some pure noise.
    task automatic build_name();
        int         labels;
        int         len;
        int         lim;
        int         l;
        int         i;
        int         pos;
        logic [7:0] b;
        name_buf.delete();
        if ($urandom_range(99) < 12) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                b = 8'($urandom_range(255));
                name_buf.push_back(b);
            end
        end else begin
            labels = $urandom_range(1, 4);
            for (l = 0; l < labels; l++) begin
                if (l != 0) begin
                    name_buf.push_back(CH_DOT);
                end
                if ($urandom_range(99) < 20) begin
                    len = int'(label_limit) - 1 + $urandom_range(0, 2);
                    if (len < 1) begin
                        len = 1;
                    end
                end else if ($urandom_range(99) < 2) begin
                    len = $urandom_range(64, 130);
                end else begin
                    lim = (label_limit < 8) ? int'(label_limit) : 8;
                    len = $urandom_range(1, lim);
                end
                for (i = 0; i < len; i++) begin
                    name_buf.push_back(ldh_char(i != 0 && i != len - 1));
                end
            end
            if ($urandom_range(99) < 30) begin
                name_buf.push_back(CH_DOT);
            end
            if ($urandom_range(99) < 20) begin
                pos = $urandom_range(0, name_buf.size() - 1);
                b   = 8'($urandom_range(255));
                case ($urandom_range(3))
                    0: name_buf[pos] = CH_HYPHEN;
                    1: name_buf[pos] = CH_DOT;
                    2: name_buf[pos] = b;
                    default: name_buf[pos] = b | 8'h80;
                endcase
            end
        end
    endtask

    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n     <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= 8'h00;
        s_last    <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MAX_NAME;
        cfg_data  <= 8'h00;
        no_idle   <= 1'b0;
        items_sent  = 0;
        name_limit  = MAX_NAME_RST;
        label_limit = 8'(MAX_LABEL_RST);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_text("Az9-0.");
        send_name();
        load_text(".");
        send_name();
        load_text("..");
        send_name();
        load_text("-a-");
        send_name();
        load_text("a-.Z");
        send_name();
        name_buf = '{8'h00, 8'hff, 8'h5f};
        send_name();
        drain();
        set_limits(8'd1, 8'd1);
        load_text("ab");
        send_name();
        load_text("a.");
        send_name();

        items_sent = 0;
        phase      = 0;
        while (items_sent < NUM_ITEMS) begin
            drain();
            case (phase)
                0: set_limits(8'd255, 8'd63);
                1: set_limits(8'd1, 8'd1);
                default: begin
                    case ($urandom_range(3))
                        0, 1: name_limit = 8'($urandom_range(1, 24));
                        2: name_limit = 8'($urandom_range(1, 255));
                        default: name_limit = 8'($urandom_range(240, 255));
                    endcase
                    if ($urandom_range(1) == 1) begin
                        label_limit = 8'($urandom_range(1, 8));
                    end else begin
                        label_limit = 8'($urandom_range(1, 63));
                    end
                    set_limits(name_limit, label_limit);
                end
            endcase
            no_idle   <= (phase == 3);
            phase_end  = items_sent + 160;
            while (items_sent < phase_end && items_sent < NUM_ITEMS) begin
                build_name();
                send_name();
                if ($urandom_range(99) < 4) begin
                    drain();
                end
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
